[rtl/cspmd_pkg.sv]
`default_nettype none

package cspmd_pkg;

    // field widths
    localparam int SAMPLE_W = 10;
    localparam int LEVEL_W  = 7;
    localparam int DUTY_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_TRIM       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TRIM      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_FLOOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_CEILING   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_MARGIN     = 3'd5;

    // reset values of the configuration registers
    localparam logic [DUTY_W-1:0]   RST_LEFT_TRIM       = 8'd10;
    localparam logic [DUTY_W-1:0]   RST_RIGHT_TRIM      = 8'd0;
    localparam logic [DUTY_W-1:0]   RST_START_THRESHOLD = 8'd40;
    localparam logic [SAMPLE_W-1:0] RST_SENSOR_FLOOR    = 10'd300;
    localparam logic [LEVEL_W-1:0]  RST_LEVEL_CEILING   = 7'd120;
    localparam logic [DUTY_W-1:0]   RST_NEAR_MARGIN     = 8'd10;

    // input command codes
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // configuration seen by the datapath
    typedef struct packed {
        logic [DUTY_W-1:0]   left_trim;
        logic [DUTY_W-1:0]   right_trim;
        logic [DUTY_W-1:0]   start_threshold;
        logic [SAMPLE_W-1:0] sensor_floor;
        logic [LEVEL_W-1:0]  level_ceiling;
        logic [DUTY_W-1:0]   near_margin;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/cspmd_cfg.sv]
`default_nettype none

module cspmd_cfg
    import cspmd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode register writes, unknown indexes ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_LEFT_TRIM:       cfg_next.left_trim       = cfg_data[DUTY_W-1:0];
                REG_RIGHT_TRIM:      cfg_next.right_trim      = cfg_data[DUTY_W-1:0];
                REG_START_THRESHOLD: cfg_next.start_threshold = cfg_data[DUTY_W-1:0];
                REG_SENSOR_FLOOR:    cfg_next.sensor_floor    = cfg_data[SAMPLE_W-1:0];
                REG_LEVEL_CEILING:   cfg_next.level_ceiling   = cfg_data[LEVEL_W-1:0];
                REG_NEAR_MARGIN:     cfg_next.near_margin     = cfg_data[DUTY_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_trim       <= RST_LEFT_TRIM;
            cfg_reg.right_trim      <= RST_RIGHT_TRIM;
            cfg_reg.start_threshold <= RST_START_THRESHOLD;
            cfg_reg.sensor_floor    <= RST_SENSOR_FLOOR;
            cfg_reg.level_ceiling   <= RST_LEVEL_CEILING;
            cfg_reg.near_margin     <= RST_NEAR_MARGIN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/cspmd_scale.sv]
`default_nettype none

module cspmd_scale
    import cspmd_pkg::*;
(
    input  wire logic [SAMPLE_W-1:0] raw,
    input  wire logic [SAMPLE_W-1:0] sensor_floor,
    input  wire logic [LEVEL_W-1:0]  level_ceiling,
    output logic      [LEVEL_W-1:0]  level
);

    logic [SAMPLE_W-1:0] above;
    logic [SAMPLE_W-3:0] shifted;

    // subtract floor with clamp at zero, drop two bits, cap at ceiling
    always_comb
    begin
        above   = (raw > sensor_floor) ? (raw - sensor_floor) : '0;
        shifted = above[SAMPLE_W-1:2];
        if (shifted > {1'b0, level_ceiling})
            level = level_ceiling;
        else
            level = shifted[LEVEL_W-1:0];
    end

endmodule

`default_nettype wire

[rtl/crossed_sensor_pwm_motor_drive_unit.sv]
`default_nettype none

// Two-channel crossed-sensor PWM motor drive.
// Input channel (in_valid / in_stall) carries one item per handshake: either a
// PWM tick (command 0) or a pair of raw 10-bit light samples (command 1).
// Output channel (out_valid / out_stall) returns one item for every input item:
// the left and right motor pin levels and the near indicator after that item.
// An accepted item sits in the input register and is worked into the state and
// result registers once the result register is free, so its result is registered
// behind the input register. One item is accepted every cycle while results are taken.
// When the receiver stalls, the result register holds and the input register
// fills, after which in_stall is raised; no item is lost or repeated.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the
// next clock edge and should be made while no item is in flight.
// Reset (rst_n low, asynchronous) clears the counter, levels, duties and pins,
// empties both stages and loads the default configuration.

module crossed_sensor_pwm_motor_drive_unit
    import cspmd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  command,
    input  wire logic [SAMPLE_W-1:0]   left_sample,
    input  wire logic [SAMPLE_W-1:0]   right_sample,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       left_pin,
    output logic                       right_pin,
    output logic                       near_led
);

    cfg_t cfg;

    // input stage
    logic                in_valid_reg;
    logic                command_reg;
    logic [SAMPLE_W-1:0] left_sample_reg;
    logic [SAMPLE_W-1:0] right_sample_reg;

    // output stage and block state
    logic                out_valid_reg;
    logic [DUTY_W-1:0]   tick_counter_reg, tick_counter_next;
    logic [LEVEL_W-1:0]  left_level_reg, left_level_next;
    logic [LEVEL_W-1:0]  right_level_reg, right_level_next;
    logic [DUTY_W-1:0]   left_duty_reg, left_duty_next;
    logic [DUTY_W-1:0]   right_duty_reg, right_duty_next;
    logic                left_out_reg, left_out_next;
    logic                right_out_reg, right_out_next;
    logic                led_out_reg, led_out_next;

    logic                out_load;
    logic                in_load;
    logic [LEVEL_W-1:0]  left_scaled;
    logic [LEVEL_W-1:0]  right_scaled;
    logic [LEVEL_W-1:0]  level_diff;

    cspmd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cspmd_scale u_scale_left (
        .raw           (left_sample_reg),
        .sensor_floor  (cfg.sensor_floor),
        .level_ceiling (cfg.level_ceiling),
        .level         (left_scaled)
    );

    cspmd_scale u_scale_right (
        .raw           (right_sample_reg),
        .sensor_floor  (cfg.sensor_floor),
        .level_ceiling (cfg.level_ceiling),
        .level         (right_scaled)
    );

    // pipeline flow control
    assign out_load = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !out_load;
    assign in_load  = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            command_reg      <= command;
            left_sample_reg  <= left_sample;
            right_sample_reg <= right_sample;
        end
    end

    // next state for one item
    always_comb
    begin
        tick_counter_next = tick_counter_reg;
        left_level_next   = left_level_reg;
        right_level_next  = right_level_reg;
        left_duty_next    = left_duty_reg;
        right_duty_next   = right_duty_reg;
        left_out_next     = left_out_reg;
        right_out_next    = right_out_reg;
        led_out_next      = led_out_reg;
        level_diff        = (left_scaled > right_scaled) ? (left_scaled - right_scaled)
                                                         : (right_scaled - left_scaled);
        if (command_reg == CMD_SAMPLE)
        begin
            // crossed wiring: left sensor drives right motor
            led_out_next     = ({1'b0, level_diff} < cfg.near_margin);
            right_level_next = left_scaled;
            left_level_next  = right_scaled;
        end
        else
        begin
            tick_counter_next = tick_counter_reg + 1'b1;
            // period start: latch duties and raise each pin whose duty exceeds the start threshold
            if (tick_counter_next == '0)
            begin
                left_duty_next  = {1'b0, left_level_reg} + cfg.left_trim;
                right_duty_next = {1'b0, right_level_reg} + cfg.right_trim;
                if (left_duty_next > cfg.start_threshold)
                    left_out_next = 1'b1;
                if (right_duty_next > cfg.start_threshold)
                    right_out_next = 1'b1;
            end
            // end of high phase
            if (tick_counter_next == left_duty_next)
                left_out_next = 1'b0;
            if (tick_counter_next == right_duty_next)
                right_out_next = 1'b0;
        end
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            tick_counter_reg <= '0;
            left_level_reg   <= '0;
            right_level_reg  <= '0;
            left_duty_reg    <= '0;
            right_duty_reg   <= '0;
            left_out_reg     <= 1'b0;
            right_out_reg    <= 1'b0;
            led_out_reg      <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || !out_stall)
                out_valid_reg <= in_valid_reg;
            if (out_load)
            begin
                tick_counter_reg <= tick_counter_next;
                left_level_reg   <= left_level_next;
                right_level_reg  <= right_level_next;
                left_duty_reg    <= left_duty_next;
                right_duty_reg   <= right_duty_next;
                left_out_reg     <= left_out_next;
                right_out_reg    <= right_out_next;
                led_out_reg      <= led_out_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign left_pin  = left_out_reg;
    assign right_pin = right_out_reg;
    assign near_led  = led_out_reg;

endmodule

`default_nettype wire
